@@ design/dpf_pkg.sv @@
// ----------------------------------------------------------------------------
// dpf_pkg - shared types and constants of the defect pixel finder
// Field widths, register indexes, reset values and the back-end states.
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int PIX_IN_W   = 16;   // pixel_value field width
    localparam int POS_OUT_W  = 13;   // column / row field width
    localparam int STAT_W     = 24;   // mean_q8 / sigma_q8 width
    localparam int TOT_W      = 25;   // kept/dead/hot total width
    localparam int FW_W       = 14;   // frame_width register width
    localparam int NSIG_W     = 12;   // nsigma_q4 register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int POS_CMP_W  = 15;   // position compare width, covers 2^14
    localparam int MSQ_W      = 2 * STAT_W;

    localparam logic [FW_W-1:0]   FW_RESET   = 14'd4096;
    localparam logic [NSIG_W-1:0] NSIG_RESET = 12'd160;
    localparam logic [STAT_W-1:0] STAT_MAX   = {STAT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH = 2'd0,
        CFG_NSIGMA      = 2'd1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        BK_RUN,
        BK_MEAN_GO,
        BK_MEAN_WAIT,
        BK_VAR_GO,
        BK_VAR_WAIT,
        BK_MSQ,
        BK_ROOT_GO,
        BK_ROOT_WAIT,
        BK_EMIT
    } t_back_state;

endpackage

@@ design/dpf_if.sv @@
// ----------------------------------------------------------------------------
// dpf_if - handshake channels of the defect pixel finder
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface dpf_pix_if;
    import dpf_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIX_IN_W-1:0] pixel_value;
    logic                last_of_frame;
    logic                new_image;
    modport source (output valid, pixel_value, last_of_frame, new_image, input ready);
    modport sink   (input valid, pixel_value, last_of_frame, new_image, output ready);
endinterface

interface dpf_res_if;
    import dpf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [POS_OUT_W-1:0] column;
    logic [POS_OUT_W-1:0] row;
    logic                 is_dead;
    logic                 is_hot;
    logic                 frame_done;
    logic [STAT_W-1:0]    mean_q8;
    logic [STAT_W-1:0]    sigma_q8;
    logic [TOT_W-1:0]     kept_total;
    logic                 converged;
    logic [TOT_W-1:0]     dead_total;
    logic [TOT_W-1:0]     hot_total;
    modport source (output valid, column, row, is_dead, is_hot, frame_done, mean_q8,
                    sigma_q8, kept_total, converged, dead_total, hot_total, input ready);
    modport sink   (input valid, column, row, is_dead, is_hot, frame_done, mean_q8,
                    sigma_q8, kept_total, converged, dead_total, hot_total, output ready);
endinterface

interface dpf_cfg_if;
    import dpf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/dpf_fifo.sv @@
// ----------------------------------------------------------------------------
// dpf_fifo - short queue between front and back
// Four-entry register queue, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module dpf_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

@@ design/dpf_front.sv @@
// ----------------------------------------------------------------------------
// dpf_front - pixel intake
// Accepts pixels, tracks column and row, flags dead pixels, queues words.
// ----------------------------------------------------------------------------
module dpf_front #(
    parameter int PIXEL_BITS = 16,
    parameter int POS_BITS   = 13
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    dpf_pix_if.sink                   i_pix,
    input  logic [dpf_pkg::FW_W-1:0]  i_frame_width,
    input  logic                      i_full,
    output logic                      o_push,
    output logic [PIXEL_BITS+2*POS_BITS+2:0] o_item
);
    import dpf_pkg::*;

    logic [POS_BITS-1:0]   r_col, r_row;
    logic [POS_BITS-1:0]   n_col, n_row;
    logic [POS_BITS-1:0]   w_col, w_row;
    logic [PIXEL_BITS-1:0] w_pix;
    logic [POS_CMP_W-1:0]  w_width;
    logic [POS_CMP_W-1:0]  w_limit;
    logic                  w_dead;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    assign w_pix   = i_pix.pixel_value[PIXEL_BITS-1:0];
    assign w_dead  = (w_pix == '0);
    // a new image restarts the position before this pixel
    assign w_col   = i_pix.new_image ? '0 : r_col;
    assign w_row   = i_pix.new_image ? '0 : r_row;
    assign w_limit = POS_CMP_W'(1) << POS_BITS;

    always_comb begin
        w_width = POS_CMP_W'(i_frame_width);
        if (w_width == '0) begin
            w_width = POS_CMP_W'(1);
        end else if (w_width > w_limit) begin
            w_width = w_limit;
        end
        if (i_pix.last_of_frame) begin
            n_col = '0;
            n_row = '0;
        end else if (POS_CMP_W'(w_col) + POS_CMP_W'(1) >= w_width) begin
            n_col = '0;
            n_row = w_row + 1'b1;
        end else begin
            n_col = w_col + 1'b1;
            n_row = w_row;
        end
    end

    assign o_item = {w_pix, w_col, w_row, w_dead, i_pix.last_of_frame, i_pix.new_image};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule

@@ design/dpf_div.sv @@
// ----------------------------------------------------------------------------
// dpf_div - restoring divider
// One quotient bit per cycle; done pulses once after the last quotient bit.
// ----------------------------------------------------------------------------
module dpf_div #(
    parameter int DW = 72,
    parameter int VW = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem, r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [VW:0]   w_t;
    logic          w_ge;

    assign w_t        = {r_rem, r_q[DW-1]};
    assign w_ge       = (w_t >= {1'b0, r_d});
    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_ge};
            r_rem <= w_ge ? VW'(w_t - {1'b0, r_d}) : VW'(w_t);
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ design/dpf_sqrt.sv @@
// ----------------------------------------------------------------------------
// dpf_sqrt - digit-by-digit integer square root
// One root bit per cycle; floor of the root, done pulses once.
// ----------------------------------------------------------------------------
module dpf_sqrt #(
    parameter int SW = 72
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [SW-1:0]             i_value,
    output logic                      o_done,
    output logic [(SW+SW%2)/2-1:0]    o_root
);
    localparam int EW = SW + SW % 2;
    localparam int HW = EW / 2;
    localparam int RW = HW + 3;
    localparam int CW = $clog2(HW + 1);

    logic [EW-1:0] r_v;
    logic [HW-1:0] r_root;
    logic [RW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [RW-1:0] w_nrem, w_trial;
    logic          w_ge;

    assign w_nrem  = {r_rem[RW-3:0], r_v[EW-1:EW-2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_nrem >= w_trial);
    assign o_done  = r_done;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= EW'(i_value);
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_v    <= {r_v[EW-3:0], 2'b00};
            r_root <= {r_root[HW-2:0], w_ge};
            r_rem  <= w_ge ? (w_nrem - w_trial) : w_nrem;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(HW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ design/dpf_back.sv @@
// ----------------------------------------------------------------------------
// dpf_back - clipping, accumulation and frame-end statistics
// Classes queued pixels against the estimate, sums kept pixels, and at
// frame end derives mean and sigma with the shared divider and root unit.
// ----------------------------------------------------------------------------
module dpf_back #(
    parameter int PIXEL_BITS = 16,
    parameter int COUNT_BITS = 24,
    parameter int POS_BITS   = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [PIXEL_BITS+2*POS_BITS+2:0] i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  logic [dpf_pkg::NSIG_W-1:0] i_nsigma,
    dpf_res_if.source                  o_res
);
    import dpf_pkg::*;

    localparam int CNTW = COUNT_BITS + 1;
    localparam int SUMW = PIXEL_BITS + COUNT_BITS;
    localparam int SQW  = 2 * PIXEL_BITS + COUNT_BITS;
    localparam int DW   = SQW + 16;
    localparam int HW   = (DW + DW % 2) / 2;
    localparam int HOTW = STAT_W + NSIG_W;

    t_back_state r_state, n_state;

    // queued word
    logic [PIXEL_BITS-1:0] w_pix;
    logic [POS_BITS-1:0]   w_col, w_row;
    logic                  w_dead, w_last, w_fresh;

    // estimate and pass state
    logic [STAT_W-1:0] r_mean, r_sigma;
    logic              r_inf;
    logic [CNTW-1:0]   r_prev;
    logic              r_prev_ok;
    logic [SUMW-1:0]   r_sum, n_sum;
    logic [SQW-1:0]    r_sq, n_sq;
    logic [CNTW-1:0]   r_kept, n_kept, r_dcnt, n_dcnt, r_hcnt, n_hcnt;

    // frame-end work
    logic [STAT_W-1:0]   r_mnew, r_snew;
    logic [DW-1:0]       r_ex2;
    logic [MSQ_W-1:0]    r_msq;
    logic [POS_BITS-1:0] r_pcol, r_prow;
    logic                r_pdead, r_phot;

    // classification
    logic [STAT_W-1:0]       w_bmean, w_bsig, w_pq, w_diff;
    logic                    w_binf, w_above, w_keep, w_hot;
    logic [STAT_W+1:0]       w_thr3;
    logic [HOTW-1:0]         w_thrh, w_diff16;
    logic [2*PIXEL_BITS-1:0] w_p2;
    logic [SUMW:0]           w_sum_add;
    logic [SQW:0]            w_sq_add;
    logic [CNTW-1:0]         w_bkept, w_bdcnt, w_bhcnt;
    logic [SUMW-1:0]         w_bsum;
    logic [SQW-1:0]          w_bsq;

    // output register
    logic                 r_ov;
    logic [POS_OUT_W-1:0] r_ocol, r_orow;
    logic                 r_odead, r_ohot, r_odone, r_oconv;
    logic [STAT_W-1:0]    r_omean, r_osig;
    logic [TOT_W-1:0]     r_okept, r_odtot, r_ohtot;
    logic                 w_out_free, w_run_go, w_emit_go;

    // width adapters
    logic [POS_BITS+POS_OUT_W-1:0] w_col_x, w_row_x;
    logic [CNTW+TOT_W-1:0]         w_kept_x, w_dcnt_x, w_hcnt_x;

    // shared units
    logic          w_div_start, w_div_done;
    logic [DW-1:0] w_div_num, w_div_q;
    logic          w_sq_start, w_sq_done;
    logic [DW-1:0] w_sq_in;
    logic [HW-1:0] w_root;

    assign {w_pix, w_col, w_row, w_dead, w_last, w_fresh} = i_item;

    assign w_out_free = !r_ov || o_res.ready;
    assign w_run_go   = (r_state == BK_RUN) && !i_empty && w_out_free;
    assign w_emit_go  = (r_state == BK_EMIT) && w_out_free;
    assign o_pop      = w_run_go;

    // a new image restarts estimate and pass before classing this pixel
    assign w_binf  = w_fresh || r_inf;
    assign w_bmean = w_fresh ? '0 : r_mean;
    assign w_bsig  = w_fresh ? '0 : r_sigma;
    assign w_bsum  = w_fresh ? '0 : r_sum;
    assign w_bsq   = w_fresh ? '0 : r_sq;
    assign w_bkept = w_fresh ? '0 : r_kept;
    assign w_bdcnt = w_fresh ? '0 : r_dcnt;
    assign w_bhcnt = w_fresh ? '0 : r_hcnt;

    assign w_pq     = STAT_W'(w_pix) << 8;
    assign w_above  = (w_pq > w_bmean);
    assign w_diff   = w_above ? (w_pq - w_bmean) : (w_bmean - w_pq);
    assign w_thr3   = (STAT_W+2)'(w_bsig) + ((STAT_W+2)'(w_bsig) << 1);
    assign w_thrh   = HOTW'(i_nsigma) * HOTW'(w_bsig);
    assign w_diff16 = HOTW'(w_diff) << 4;

    always_comb begin
        if (w_binf) begin
            w_keep = !w_dead;
            w_hot  = (i_nsigma == '0) && w_above;
        end else begin
            w_keep = !w_dead && ((STAT_W+2)'(w_diff) < w_thr3);
            w_hot  = w_above && (w_diff16 > w_thrh);
        end
    end

    // saturating accumulators
    assign w_p2      = (2*PIXEL_BITS)'(w_pix) * (2*PIXEL_BITS)'(w_pix);
    assign w_sum_add = (SUMW+1)'(w_bsum) + (SUMW+1)'(w_pix);
    assign w_sq_add  = (SQW+1)'(w_bsq) + (SQW+1)'(w_p2);

    always_comb begin
        n_sum  = w_bsum;
        n_sq   = w_bsq;
        n_kept = w_bkept;
        n_dcnt = w_bdcnt;
        n_hcnt = w_bhcnt;
        if (w_keep) begin
            n_sum  = w_sum_add[SUMW] ? '1 : w_sum_add[SUMW-1:0];
            n_sq   = w_sq_add[SQW] ? '1 : w_sq_add[SQW-1:0];
            n_kept = (&w_bkept) ? w_bkept : w_bkept + 1'b1;
        end
        if (w_dead) begin
            n_dcnt = (&w_bdcnt) ? w_bdcnt : w_bdcnt + 1'b1;
        end
        if (w_hot) begin
            n_hcnt = (&w_bhcnt) ? w_bhcnt : w_bhcnt + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN:       if (w_run_go && w_last) n_state = BK_MEAN_GO;
            BK_MEAN_GO:   n_state = (r_kept == '0) ? BK_EMIT : BK_MEAN_WAIT;
            BK_MEAN_WAIT: if (w_div_done) n_state = BK_VAR_GO;
            BK_VAR_GO:    n_state = BK_VAR_WAIT;
            BK_VAR_WAIT:  if (w_div_done) n_state = BK_MSQ;
            BK_MSQ:       n_state = BK_ROOT_GO;
            BK_ROOT_GO:   n_state = BK_ROOT_WAIT;
            BK_ROOT_WAIT: if (w_sq_done) n_state = BK_EMIT;
            BK_EMIT:      if (w_emit_go) n_state = BK_RUN;
            default:      n_state = BK_RUN;
        endcase
    end

    // unit controls
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = DW'({r_sum, 8'h00}) + DW'(r_kept >> 1);
        w_sq_start  = 1'b0;
        case (r_state)
            BK_MEAN_GO: w_div_start = (r_kept != '0);
            BK_VAR_GO: begin
                w_div_start = 1'b1;
                w_div_num   = {r_sq, 16'h0000};
            end
            BK_ROOT_GO: w_sq_start = 1'b1;
            default: ;
        endcase
    end

    assign w_sq_in = (r_ex2 > DW'(r_msq)) ? (r_ex2 - DW'(r_msq)) : '0;

    dpf_div #(
        .DW (DW),
        .VW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (r_kept),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    dpf_sqrt #(
        .SW (DW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_value (w_sq_in),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_col_x  = (POS_BITS+POS_OUT_W)'(w_col);
    assign w_row_x  = (POS_BITS+POS_OUT_W)'(w_row);
    assign w_kept_x = (CNTW+TOT_W)'(r_kept);
    assign w_dcnt_x = (CNTW+TOT_W)'(r_dcnt);
    assign w_hcnt_x = (CNTW+TOT_W)'(r_hcnt);

    always_ff @(posedge i_clk) begin
        // frame-end datapath
        if (w_run_go && w_last) begin
            r_pcol  <= w_col;
            r_prow  <= w_row;
            r_pdead <= w_dead;
            r_phot  <= w_hot;
        end
        if (r_state == BK_MEAN_GO && r_kept == '0) begin
            r_mnew <= '0;
            r_snew <= '0;
        end
        if (r_state == BK_MEAN_WAIT && w_div_done) begin
            r_mnew <= (w_div_q > DW'(STAT_MAX)) ? STAT_MAX : w_div_q[STAT_W-1:0];
        end
        if (r_state == BK_VAR_WAIT && w_div_done) begin
            r_ex2 <= w_div_q;
        end
        if (r_state == BK_MSQ) begin
            r_msq <= MSQ_W'(r_mnew) * MSQ_W'(r_mnew);
        end
        if (r_state == BK_ROOT_WAIT && w_sq_done) begin
            r_snew <= (w_root > HW'(STAT_MAX)) ? STAT_MAX : w_root[STAT_W-1:0];
        end
        // result payload
        if (w_run_go && !w_last) begin
            r_ocol  <= w_col_x[POS_OUT_W-1:0];
            r_orow  <= w_row_x[POS_OUT_W-1:0];
            r_odead <= w_dead;
            r_ohot  <= w_hot;
            r_odone <= 1'b0;
            r_omean <= '0;
            r_osig  <= '0;
            r_okept <= '0;
            r_oconv <= 1'b0;
            r_odtot <= '0;
            r_ohtot <= '0;
        end else if (w_emit_go) begin
            r_ocol  <= POS_OUT_W'(r_pcol);
            r_orow  <= POS_OUT_W'(r_prow);
            r_odead <= r_pdead;
            r_ohot  <= r_phot;
            r_odone <= 1'b1;
            r_omean <= r_mnew;
            r_osig  <= r_snew;
            r_okept <= w_kept_x[TOT_W-1:0];
            r_oconv <= r_prev_ok && (r_prev == r_kept);
            r_odtot <= w_dcnt_x[TOT_W-1:0];
            r_ohtot <= w_hcnt_x[TOT_W-1:0];
        end

        if (!i_rst_n) begin
            r_state   <= BK_RUN;
            r_ov      <= 1'b0;
            r_mean    <= '0;
            r_sigma   <= '0;
            r_inf     <= 1'b1;
            r_prev    <= '0;
            r_prev_ok <= 1'b0;
            r_sum     <= '0;
            r_sq      <= '0;
            r_kept    <= '0;
            r_dcnt    <= '0;
            r_hcnt    <= '0;
        end else begin
            r_state <= n_state;
            if (w_run_go && !w_last) begin
                r_ov <= 1'b1;
            end else if (w_emit_go) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (w_run_go) begin
                r_sum  <= n_sum;
                r_sq   <= n_sq;
                r_kept <= n_kept;
                r_dcnt <= n_dcnt;
                r_hcnt <= n_hcnt;
                if (w_fresh) begin
                    r_mean    <= '0;
                    r_sigma   <= '0;
                    r_inf     <= 1'b1;
                    r_prev    <= '0;
                    r_prev_ok <= 1'b0;
                end
            end
            if (w_emit_go) begin
                r_prev    <= r_kept;
                r_prev_ok <= 1'b1;
                r_mean    <= r_mnew;
                r_sigma   <= r_snew;
                r_inf     <= 1'b0;
                r_sum     <= '0;
                r_sq      <= '0;
                r_kept    <= '0;
                r_dcnt    <= '0;
                r_hcnt    <= '0;
            end
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.column     = r_ocol;
    assign o_res.row        = r_orow;
    assign o_res.is_dead    = r_odead;
    assign o_res.is_hot     = r_ohot;
    assign o_res.frame_done = r_odone;
    assign o_res.mean_q8    = r_omean;
    assign o_res.sigma_q8   = r_osig;
    assign o_res.kept_total = r_okept;
    assign o_res.converged  = r_oconv;
    assign o_res.dead_total = r_odtot;
    assign o_res.hot_total  = r_ohtot;
endmodule

@@ design/sigma_clip_defect_pixel_finder_unit.sv @@
// ----------------------------------------------------------------------------
// sigma_clip_defect_pixel_finder_unit - iterative sigma-clip hot/dead finder
// Classes dark-frame pixels against the previous pass estimate and derives a
// new mean and sigma at each frame end.
// ----------------------------------------------------------------------------
//
//  channel   dir   word
//  --------  ----  ---------------------------------------------------------
//  i_pix     in    pixel_value, last_of_frame, new_image
//  o_res     out   column, row, is_dead, is_hot, frame_done, mean/sigma,
//                  kept/dead/hot totals, converged
//  i_cfg     in    index (0 frame_width, 1 nsigma_q4), data
//
//  One pixel word per cycle within a pass while the queue has room. The word
//  that closes a pass holds the back end for two long divisions of DW bits
//  each (DW = 2*PIXEL_BITS + COUNT_BITS + 16) and then a square root of
//  DW/2 bits, one bit per cycle on the shared units. The front keeps taking
//  pixels until the four-word queue fills. Reset (i_rst_n low at a clock
//  edge) restores the power-up registers and an infinite sigma. Config
//  writes are always ready.
//
module sigma_clip_defect_pixel_finder_unit #(
    parameter int PIXEL_BITS = 16,
    parameter int COUNT_BITS = 24,
    parameter int POS_BITS   = 13
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpf_pix_if.sink    i_pix,
    dpf_cfg_if.sink    i_cfg,
    dpf_res_if.source  o_res
);
    import dpf_pkg::*;

    localparam int IW = PIXEL_BITS + 2 * POS_BITS + 3;

    logic [FW_W-1:0]   r_frame_width;
    logic [NSIG_W-1:0] r_nsigma;

    logic          w_push, w_full, w_pop, w_empty;
    logic [IW-1:0] w_in_item, w_out_item;

    // configuration registers, writes never stall
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FW_RESET;
            r_nsigma      <= NSIG_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_FRAME_WIDTH: r_frame_width <= FW_W'(i_cfg.data);
                CFG_NSIGMA:      r_nsigma      <= i_cfg.data[NSIG_W-1:0];
                default: ;
            endcase
        end
    end

    // front: intake, position, dead flag
    dpf_front #(
        .PIXEL_BITS (PIXEL_BITS),
        .POS_BITS   (POS_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (i_pix),
        .i_frame_width (r_frame_width),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_in_item)
    );

    // decoupling queue
    dpf_fifo #(
        .WIDTH (IW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_out_item),
        .o_empty (w_empty)
    );

    // back: clip test, accumulation, frame-end statistics
    dpf_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .COUNT_BITS (COUNT_BITS),
        .POS_BITS   (POS_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_out_item),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_nsigma (r_nsigma),
        .o_res    (o_res)
    );
endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - self-checking bench of the sigma-clip defect pixel finder
// Streams dark-frame passes through the pixel channel, predicts every result
// word in a local model of the block and checks each one field by field.
// Covers the register extremes, the special cases and random idling/stalls.
// ----------------------------------------------------------------------------
module testbench;
    import dpf_pkg::*;

    localparam int WDOG_LIMIT  = 6000;   // idle cycles before the run is abandoned
    localparam int DRAIN_WAIT  = 200;    // settling pause for the back end after all expected words
    localparam int ITEM_TARGET = 950;

    typedef struct packed {
        logic [POS_OUT_W-1:0] column;
        logic [POS_OUT_W-1:0] row;
        logic                 is_dead;
        logic                 is_hot;
        logic                 frame_done;
        logic [STAT_W-1:0]    mean_q8;
        logic [STAT_W-1:0]    sigma_q8;
        logic [TOT_W-1:0]     kept_total;
        logic                 converged;
        logic [TOT_W-1:0]     dead_total;
        logic [TOT_W-1:0]     hot_total;
    } t_px_result;

    logic i_clk;
    logic i_rst_n;

    dpf_pix_if pix ();
    dpf_res_if res ();
    dpf_cfg_if cfg ();

    sigma_clip_defect_pixel_finder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .i_cfg   (cfg.sink),
        .o_res   (res.source)
    );

    // ---- expected result words, oldest first
    t_px_result pending_results[$];
    int         fail_count;
    int         sent_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_left;           // long receiver hold-off, counted by the receiver
    int         quiet_cycles;

    // ---- local copy of block state and registers
    logic [FW_W-1:0]   model_width;
    logic [NSIG_W-1:0] model_nsig;
    logic [63:0] acc_sum, acc_sq, acc_n, prev_n;
    logic        prev_ok;
    logic [63:0] est_mean, est_sigma;
    logic        est_inf;
    logic [63:0] pos_col, pos_row, n_dead, n_hot;

    localparam logic [63:0] CNT_SAT = (64'd1 << 25) - 1;
    localparam logic [63:0] SUM_SAT = (64'd1 << 40) - 1;
    localparam logic [63:0] SQ_SAT  = (64'd1 << 56) - 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sat_inc(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
        if (a > lim || b > lim - a) return lim;
        return a + b;
    endfunction

    function automatic void clear_pass_state();
        acc_sum = 0; acc_sq = 0; acc_n = 0;
        n_dead = 0; n_hot = 0; pos_col = 0; pos_row = 0;
    endfunction

    function automatic void clear_estimate();
        est_mean = 0; est_sigma = 0; est_inf = 1'b1;
        prev_n = 0; prev_ok = 1'b0;
    endfunction

    // Classify one accepted pixel word and queue the word the block must return.
    function automatic void predict_pixel(logic [15:0] v, logic last, logic fresh);
        t_px_result  r;
        logic [63:0] p, pq, diff, w, n, m, s, q, rem, ex2, msq, rad, root, bitv;
        logic        dead, hot, keep, above;
        if (fresh) begin
            clear_pass_state();
            clear_estimate();
        end
        p     = {48'd0, v};
        pq    = p << 8;
        dead  = (p == 0);
        above = pq > est_mean;
        diff  = above ? pq - est_mean : est_mean - pq;
        if (est_inf) begin
            keep = !dead;
            hot  = (model_nsig == 0) && above;
        end else begin
            keep = !dead && diff < 3 * est_sigma;
            hot  = above && (diff << 4) > {52'd0, model_nsig} * est_sigma;
        end
        if (dead) n_dead = sat_inc(n_dead, 1, CNT_SAT);
        if (hot)  n_hot  = sat_inc(n_hot, 1, CNT_SAT);
        if (keep) begin
            acc_sum = sat_inc(acc_sum, p, SUM_SAT);
            acc_sq  = sat_inc(acc_sq, p * p, SQ_SAT);
            acc_n   = sat_inc(acc_n, 1, CNT_SAT);
        end
        r = '0;
        r.column  = pos_col[POS_OUT_W-1:0];
        r.row     = pos_row[POS_OUT_W-1:0];
        r.is_dead = dead;
        r.is_hot  = hot;
        // width 0 behaves as 1, anything past 8192 clamps
        w = {50'd0, model_width};
        if (w == 0) w = 1;
        if (w > 8192) w = 8192;
        if (pos_col + 1 >= w) begin
            pos_col = 0;
            pos_row = (pos_row + 1) & 64'h1FFF;
        end else begin
            pos_col++;
        end
        if (last) begin
            n = acc_n; m = 0; s = 0;
            if (n != 0) begin
                q   = acc_sq / n;
                rem = acc_sq % n;
                ex2 = (q << 16) + (rem << 16) / n;
                m   = ((acc_sum << 8) + n / 2) / n;
                if (m > 64'hFFFFFF) m = 64'hFFFFFF;
                msq = m * m;
                if (ex2 > msq) begin
                    // digit-by-digit integer square root
                    rad  = ex2 - msq;
                    root = 0;
                    bitv = 64'd1 << 62;
                    while (bitv > rad) bitv >>= 2;
                    while (bitv != 0) begin
                        if (rad >= root + bitv) begin
                            rad  = rad - (root + bitv);
                            root = (root >> 1) + bitv;
                        end else begin
                            root >>= 1;
                        end
                        bitv >>= 2;
                    end
                    s = root;
                end
                if (s > 64'hFFFFFF) s = 64'hFFFFFF;
            end
            r.frame_done = 1'b1;
            r.mean_q8    = m[STAT_W-1:0];
            r.sigma_q8   = s[STAT_W-1:0];
            r.kept_total = n[TOT_W-1:0];
            r.converged  = prev_ok && (prev_n == n);
            r.dead_total = n_dead[TOT_W-1:0];
            r.hot_total  = n_hot[TOT_W-1:0];
            prev_n    = n;
            prev_ok   = 1'b1;
            est_mean  = m;
            est_sigma = s;
            est_inf   = 1'b0;
            clear_pass_state();
        end
        pending_results.push_back(r);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        fail_count++;
    endtask

    // ---- result side: check accepted words, drive ready, count long hold-off
    always @(posedge i_clk) begin
        t_px_result want;
        if (i_rst_n && res.valid && res.ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected word", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (res.column !== want.column)     report("column", res.column, want.column);
                if (res.row !== want.row)           report("row", res.row, want.row);
                if (res.is_dead !== want.is_dead)   report("is_dead", res.is_dead, want.is_dead);
                if (res.is_hot !== want.is_hot)     report("is_hot", res.is_hot, want.is_hot);
                if (res.frame_done !== want.frame_done)
                    report("frame_done", res.frame_done, want.frame_done);
                if (res.mean_q8 !== want.mean_q8)   report("mean_q8", res.mean_q8, want.mean_q8);
                if (res.sigma_q8 !== want.sigma_q8)
                    report("sigma_q8", res.sigma_q8, want.sigma_q8);
                if (res.kept_total !== want.kept_total)
                    report("kept_total", res.kept_total, want.kept_total);
                if (res.converged !== want.converged)
                    report("converged", res.converged, want.converged);
                if (res.dead_total !== want.dead_total)
                    report("dead_total", res.dead_total, want.dead_total);
                if (res.hot_total !== want.hot_total)
                    report("hot_total", res.hot_total, want.hot_total);
            end
        end
        if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ---- watchdog: cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One pixel word; random sender gaps in front of it.
    task automatic send_pixel(logic [15:0] v, logic last, logic fresh);
        int gap;
        if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            pix.valid <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge i_clk);
        end
        pix.valid         <= 1'b1;
        pix.pixel_value   <= v;
        pix.last_of_frame <= last;
        pix.new_image     <= fresh;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        predict_pixel(v, last, fresh);
        sent_count++;
    endtask

    task automatic idle_pixel_side();
        pix.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for all expected words, then let the back end settle.
    task automatic drain();
        idle_pixel_side();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] d);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) model_width = d[FW_W-1:0];
        else                        model_nsig  = d[NSIG_W-1:0];
    endtask

    // Pixel drawn around a per-image level, with rare dead and hot outliers.
    function automatic logic [15:0] draw_pixel(int level, int spread);
        int v;
        case ($urandom_range(19, 0))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(16'hFFFF, 0));
            default: begin
                v = level + $urandom_range(2 * spread, 0) - spread;
                if (v < 1) v = 1;
                if (v > 65535) v = 65535;
                return v[15:0];
            end
        endcase
    endfunction

    // One image: a frame re-streamed for several passes.
    task automatic run_image(int npix, int passes);
        logic [15:0] frame[$];
        int level, spread;
        level  = $urandom_range(60000, 20);
        spread = $urandom_range(level < 400 ? level : 400, 0);
        for (int i = 0; i < npix; i++) frame.push_back(draw_pixel(level, spread));
        for (int ps = 0; ps < passes; ps++)
            for (int i = 0; i < npix; i++)
                send_pixel(frame[i], i == npix - 1, ps == 0 && i == 0);
    endtask

    // Reset defaults; dead, full-scale, convergence over passes, empty pass.
    task automatic test_directed();
        logic [15:0] vals[6] = '{16'd0, 16'hFFFF, 16'd1, 16'd1000, 16'd1000, 16'd1002};
        for (int ps = 0; ps < 3; ps++)
            for (int i = 0; i < 6; i++) send_pixel(vals[i], i == 5, ps == 0 && i == 0);
        // all-dead pass: nothing kept, estimate falls to zero
        send_pixel(16'd0, 1'b0, 1'b1);
        send_pixel(16'd0, 1'b1, 1'b0);
        send_pixel(16'd7, 1'b1, 1'b0);
        // single-pixel passes
        send_pixel(16'h8000, 1'b1, 1'b1);
        send_pixel(16'h7FFF, 1'b1, 1'b0);
    endtask

    // Register extremes: width 0, 1, odd, 8192, clamp above; nsigma 0 and max.
    task automatic test_registers();
        logic [CFG_DATA_W-1:0] widths[6] = '{14'd0, 14'd1, 14'd3, 14'd8192, 14'h3FFF, 14'd7};
        logic [CFG_DATA_W-1:0] nsigs[4]  = '{14'd0, 14'hFFF, 14'h3FFF, 14'd16};
        for (int i = 0; i < 6; i++) begin
            write_reg(CFG_FRAME_WIDTH, widths[i]);
            write_reg(CFG_NSIGMA, nsigs[i % 4]);
            run_image($urandom_range(12, 2), 3);
        end
    endtask

    // Receiver holds off long enough to fill the queue; then a full drain pause.
    task automatic test_pressure();
        write_reg(CFG_NSIGMA, 14'd48);
        hold_left = 400;
        run_image(30, 2);
        drain();
        run_image(10, 2);
    endtask

    task automatic test_random();
        int phase;
        phase = 0;
        while (sent_count < ITEM_TARGET) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if ($urandom_range(3, 0) == 0)
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(9, 0)));
            if ($urandom_range(3, 0) == 0)
                write_reg(CFG_NSIGMA, CFG_DATA_W'($urandom_range(16'h3FFF, 0)));
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(9, 0) == 0) begin
                    // noise: unrelated words with random flags
                    repeat ($urandom_range(8, 1))
                        send_pixel(16'($urandom_range(16'hFFFF, 0)),
                                   1'($urandom_range(1, 0)),
                                   $urandom_range(3, 0) == 0);
                end else begin
                    run_image($urandom_range(30, 1), $urandom_range(5, 2));
                end
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        pix.valid         = 1'b0;
        pix.pixel_value   = '0;
        pix.last_of_frame = 1'b0;
        pix.new_image     = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_FRAME_WIDTH;
        cfg.data          = '0;
        res.ready         = 1'b0;
        fail_count        = 0;
        sent_count        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_left         = 0;
        quiet_cycles      = 0;
        model_width       = FW_RESET;
        model_nsig        = NSIG_RESET;
        clear_pass_state();
        clear_estimate();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_registers();
        test_pressure();
        test_random();

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sigma_clip_defect_pixel_finder_unit.f @@
design/dpf_pkg.sv
design/dpf_if.sv
design/dpf_fifo.sv
design/dpf_front.sv
design/dpf_div.sv
design/dpf_sqrt.sv
design/dpf_back.sv
design/sigma_clip_defect_pixel_finder_unit.sv
tb/sv/testbench.sv
